// File: rtl/rbd_pkg.sv
package rbd_pkg;

  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned CMP_W      = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  localparam logic [7:0] CTRL_REPEAT = 8'h80;

  typedef enum logic [2:0] {
    PH_CTRL = 3'b001,
    PH_REP  = 3'b010,
    PH_LIT  = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e                  phase;
    logic [7:0]              remaining;
    logic [COUNT_BITS-1:0]   total;
  } rbd_state_t;

  typedef struct packed {
    logic               valid;
    logic [7:0]         value;
    logic [7:0]         run;
    logic               eos;
    logic               status;
    logic [TOTAL_W-1:0] total;
  } rbd_res_t;

endpackage

// File: rtl/rbd_step.sv
module rbd_step
  import rbd_pkg::*;
(
  input  rbd_state_t state_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output rbd_state_t state_o,
  output rbd_res_t   res_o
);

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [7:0] n);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(n);
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] total_field(input logic [COUNT_BITS-1:0] t);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] lim;
    ext = CMP_W'(t);
    lim = CMP_W'({TOTAL_W{1'b1}});
    return (ext > lim) ? {TOTAL_W{1'b1}} : ext[TOTAL_W-1:0];
  endfunction

  logic [7:0]            run;
  logic [7:0]            rem_dec;
  logic                  pending;
  logic [COUNT_BITS-1:0] sum;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    run     = {1'b0, state_i.remaining[6:0]} + 8'd1;
    rem_dec = (state_i.remaining != 8'd0) ? state_i.remaining - 8'd1 : 8'd0;
    pending = (rem_dec != 8'd0);
    sum     = '0;
    case (state_i.phase)
      PH_REP: begin
        sum               = sat_add(state_i.total, run);
        state_o.phase     = PH_CTRL;
        state_o.remaining = 8'd0;
        state_o.total     = sum;
        res_o.valid       = 1'b1;
        res_o.value       = byte_i;
        res_o.run         = run;
        res_o.eos         = last_i;
        res_o.status      = 1'b0;
        res_o.total       = total_field(sum);
      end
      PH_LIT: begin
        sum               = sat_add(state_i.total, 8'd1);
        state_o.remaining = rem_dec;
        state_o.total     = sum;
        if (!pending) begin
          state_o.phase = PH_CTRL;
        end
        res_o.valid  = 1'b1;
        res_o.value  = byte_i;
        res_o.run    = 8'd1;
        res_o.eos    = last_i;
        res_o.status = last_i & pending;
        res_o.total  = total_field(sum);
      end
      default: begin
        if ((byte_i & CTRL_REPEAT) != 8'd0) begin
          state_o.phase     = PH_REP;
          state_o.remaining = {1'b0, byte_i[6:0]};
        end else begin
          state_o.phase     = PH_LIT;
          state_o.remaining = byte_i + 8'd1;
        end
        if (last_i) begin
          res_o.valid  = 1'b1;
          res_o.eos    = 1'b1;
          res_o.status = 1'b1;
          res_o.total  = total_field(state_i.total);
        end
      end
    endcase
    if (last_i) begin
      state_o.phase     = PH_CTRL;
      state_o.remaining = 8'd0;
      state_o.total     = '0;
    end
  end

endmodule

// File: rtl/rle_byte_run_decoder.sv
// Channel  Direction  tdata (low bit up)                          tlast          tuser
// s_axis   in         in_byte[7:0]                                in_last        -
// m_axis   out        out_value[7:0] out_run[15:8] total[39:16]   end_of_stream  status
//
// One byte is taken per cycle unless the output stalls; each passes the input register first.
// The input register feeds the decode step, which updates the run state and the
// result register in the same cycle. Control bytes that are not last give no result.
// Reset clears the run state and both valid flags. A stall at the output holds
// the input register, so at most one request waits inside while a result is held.
module rle_byte_run_decoder
  import rbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // in_byte
  input  logic                   s_axis_tlast,   // in_last
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TOTAL_W+15:0]    m_axis_tdata,   // out_value, out_run, total_bytes
  output logic                   m_axis_tlast,   // end_of_stream
  output logic                   m_axis_tuser    // status
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q, out_vld_d;
  rbd_res_t   out_q;
  rbd_state_t state_q, state_d;
  rbd_res_t   res;
  logic       adv;
  logic       s_acc;

  rbd_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (res)
  );

  assign adv           = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = res.valid;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{phase: PH_CTRL, remaining: 8'd0, total: '0};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (adv && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.total, out_q.run, out_q.value};
  assign m_axis_tlast  = out_q.eos;
  assign m_axis_tuser  = out_q.status;

endmodule
